// File: rtl/iyfp_pkg.sv
// Shared types and constants for the IMU yaw frame parser.
// No dependencies; used by every module under rtl/.
`default_nettype none

package iyfp_pkg;

    localparam logic [7:0] SYNC_BYTE          = 8'h55;
    localparam logic [7:0] PACKET_TYPE_RESET  = 8'h53;
    localparam logic [3:0] FRAME_LAST         = 4'd10;
    localparam logic [3:0] POS_ANGLE_LO       = 4'd6;
    localparam logic [3:0] POS_ANGLE_HI       = 4'd7;
    localparam logic [3:0] POS_FIRST_PAYLOAD  = 4'd2;
    localparam logic [3:0] POS_TYPE           = 4'd1;

    localparam int         FIFO_DEPTH_DEFAULT = 2;

    localparam int         ADDR_W             = 3;
    localparam int         DATA_W             = 32;
    localparam logic       REG_PACKET_TYPE    = 1'b0;

    localparam logic [7:0] DEG_SCALE          = 8'd180;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_TYPE    = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

    // One finished frame, as handed from the parser to the yaw unit.
    typedef struct packed {
        logic       ok;
        logic [7:0] angle_lo;
        logic [7:0] angle_hi;
    } frame_t;

endpackage

`default_nettype wire

// File: rtl/iyfp_fifo.sv
// Small register FIFO carrying frame records from the parser to the yaw unit.
// Depends on iyfp_pkg for the frame record type.
`default_nettype none

module iyfp_fifo #(
    parameter int DEPTH = iyfp_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  iyfp_pkg::frame_t  push_data,
    output logic              push_ready,
    input  wire               pop,
    output iyfp_pkg::frame_t  pop_data,
    output logic              pop_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    iyfp_pkg::frame_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/iyfp_front.sv
// Byte parser: sync hunt, type match, payload collection and checksum check.
// Depends on iyfp_pkg; emits one frame record per completed frame.
`default_nettype none

module iyfp_front (
    input  wire               clk,
    input  wire               rst_n,
    input  wire  [7:0]        packet_type,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire  [7:0]        rx_byte,
    output logic              push,
    output iyfp_pkg::frame_t  push_data,
    input  wire               push_ready
);

    iyfp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       lo_reg, lo_next;
    logic [7:0]       hi_reg, hi_next;
    logic             accept;
    logic             at_checksum;

    assign in_ready    = push_ready;
    assign accept      = in_valid && in_ready;
    assign at_checksum = (phase_reg == iyfp_pkg::PH_COLLECT)
                         && (count_reg >= iyfp_pkg::FRAME_LAST);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        if (accept)
        begin
            unique case (phase_reg)
                iyfp_pkg::PH_TYPE:
                begin
                    // non-matching bytes (sync included) are skipped here
                    if (rx_byte == packet_type)
                    begin
                        sum_next   = sum_reg + rx_byte;
                        phase_next = iyfp_pkg::PH_COLLECT;
                        count_next = iyfp_pkg::POS_FIRST_PAYLOAD;
                    end
                end
                iyfp_pkg::PH_COLLECT:
                begin
                    if (count_reg >= iyfp_pkg::FRAME_LAST)
                    begin
                        phase_next = iyfp_pkg::PH_HUNT;
                        count_next = '0;
                        sum_next   = '0;
                    end
                    else
                    begin
                        if (count_reg == iyfp_pkg::POS_ANGLE_LO)
                        begin
                            lo_next = rx_byte;
                        end
                        if (count_reg == iyfp_pkg::POS_ANGLE_HI)
                        begin
                            hi_next = rx_byte;
                        end
                        sum_next   = sum_reg + rx_byte;
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = iyfp_pkg::PH_HUNT;
                    if (rx_byte == iyfp_pkg::SYNC_BYTE)
                    begin
                        sum_next   = iyfp_pkg::SYNC_BYTE;
                        phase_next = iyfp_pkg::PH_TYPE;
                        count_next = iyfp_pkg::POS_TYPE;
                    end
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        push               = accept && at_checksum;
        push_data.ok       = (sum_reg == rx_byte);
        push_data.angle_lo = lo_reg;
        push_data.angle_hi = hi_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= iyfp_pkg::PH_HUNT;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

endmodule

`default_nettype wire

// File: rtl/iyfp_back.sv
// Yaw unit: converts a checked frame's raw angle to degrees and holds the yaw.
// Depends on iyfp_pkg; drives the result word register.
`default_nettype none

module iyfp_back (
    input  wire                clk,
    input  wire                rst_n,
    input  iyfp_pkg::frame_t   pop_data,
    input  wire                pop_valid,
    output logic               pop,
    output logic               out_valid,
    input  wire                out_ready,
    output logic signed [8:0]  yaw_degrees,
    output logic               checksum_ok
);

    logic               out_valid_reg, out_valid_next;
    logic signed [8:0]  yaw_held_reg, yaw_held_next;
    logic               ok_reg, ok_next;
    logic [15:0]        raw;
    logic               neg;
    logic [16:0]        mag;
    logic [24:0]        prod;
    logic [8:0]         quot;
    logic signed [8:0]  deg;

    assign pop = pop_valid && (!out_valid_reg || out_ready);

    // |raw| * 180 / 32768, truncated, then sign restored
    always_comb
    begin
        raw  = {pop_data.angle_hi, pop_data.angle_lo};
        neg  = raw[15];
        mag  = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        prod = mag * iyfp_pkg::DEG_SCALE;
        quot = prod[23:15];
        deg  = neg ? -$signed(quot) : $signed(quot);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        yaw_held_next  = yaw_held_reg;
        ok_next        = ok_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_valid_next = 1'b1;
            ok_next        = pop_data.ok;
            if (pop_data.ok)
            begin
                yaw_held_next = deg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            yaw_held_reg  <= '0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            yaw_held_reg  <= yaw_held_next;
            ok_reg        <= ok_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign yaw_degrees = yaw_held_reg;
    assign checksum_ok = ok_reg;

endmodule

`default_nettype wire

// File: rtl/imu_yaw_frame_parser.sv
// Top level of the IMU yaw frame parser: APB register, parser, queue, yaw unit.
// Depends on iyfp_pkg, iyfp_front, iyfp_fifo and iyfp_back.
`default_nettype none

// Takes one serial byte per word and finds 11-byte angle frames: sync 0x55, the
// packet_type byte, eight payload bytes and an additive checksum. Each finished
// frame yields one result word with the held yaw in whole degrees and a
// checksum_ok flag; yaw is updated only by frames whose checksum matches.
// packet_type sits at address 0. A byte is accepted every cycle while the frame
// queue has room; a frame's result goes through the frame queue to the yaw
// output register. The frame queue (FIFO_DEPTH entries) lets bytes keep flowing
// while results wait downstream; in_ready drops only when that queue is full.
module imu_yaw_frame_parser #(
    parameter int FIFO_DEPTH = iyfp_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [iyfp_pkg::ADDR_W-1:0]  paddr,
    input  wire  [iyfp_pkg::DATA_W-1:0]  pwdata,
    output logic [iyfp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [7:0]                   rx_byte,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic signed [8:0]            yaw_degrees,
    output logic                         checksum_ok
);

    logic [7:0]        packet_type_reg, packet_type_next;
    logic              reg_hit;
    iyfp_pkg::frame_t  push_data;
    iyfp_pkg::frame_t  pop_data;
    logic              push;
    logic              push_ready;
    logic              pop;
    logic              pop_valid;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[iyfp_pkg::ADDR_W-1] == iyfp_pkg::REG_PACKET_TYPE);

    always_comb
    begin
        packet_type_next = packet_type_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            packet_type_next = pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_hit)
        begin
            prdata = {{(iyfp_pkg::DATA_W - 8){1'b0}}, packet_type_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_type_reg <= iyfp_pkg::PACKET_TYPE_RESET;
        end
        else
        begin
            packet_type_reg <= packet_type_next;
        end
    end

    iyfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .packet_type (packet_type_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .push        (push),
        .push_data   (push_data),
        .push_ready  (push_ready)
    );

    iyfp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid)
    );

    iyfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_data    (pop_data),
        .pop_valid   (pop_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .yaw_degrees (yaw_degrees),
        .checksum_ok (checksum_ok)
    );

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking bench for imu_yaw_frame_parser: byte stream, APB packet-type register.
// A scoreboard class tracks the frame parser state and the expected result words.
// Depends on rtl/iyfp_pkg.sv and rtl/imu_yaw_frame_parser.sv.
`default_nettype none

module tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int SEGMENTS       = 8;
    localparam int SEGMENT_ITEMS  = 228;

    typedef struct packed {
        logic signed [8:0] yaw;
        logic              ok;
    } yaw_word_t;

    class yaw_frame_tracker;
        iyfp_pkg::phase_t phase;
        logic [3:0]  pos;
        logic [7:0]  sum;
        logic [7:0]  angle_lo;
        logic [7:0]  angle_hi;
        logic signed [8:0] yaw;
        logic [7:0]  ptype;
        yaw_word_t   pending_words[$];
        int          errors;
        int          good_frames;
        int          bad_frames;

        function new();
            phase = iyfp_pkg::PH_HUNT;
            pos = '0;
            sum = '0;
            angle_lo = '0;
            angle_hi = '0;
            yaw = '0;
            ptype = iyfp_pkg::PACKET_TYPE_RESET;
            errors = 0;
            good_frames = 0;
            bad_frames = 0;
        endfunction

        // raw * 180 / 32768, truncated toward zero
        function automatic logic signed [8:0] raw_to_deg(logic [7:0] lo, logic [7:0] hi);
            int u;
            int mag;
            int q;
            u = {16'h0, hi, lo};
            mag = u[15] ? (65536 - u) : u;
            q = (mag * 180) >> 15;
            if (u[15])
                q = -q;
            return q[8:0];
        endfunction

        function void take_byte(logic [7:0] b);
            yaw_word_t w;
            case (phase)
                iyfp_pkg::PH_TYPE:
                begin
                    // anything but the type byte is skipped, sync included
                    if (b == ptype)
                    begin
                        sum = sum + b;
                        phase = iyfp_pkg::PH_COLLECT;
                        pos = iyfp_pkg::POS_FIRST_PAYLOAD;
                    end
                end
                iyfp_pkg::PH_COLLECT:
                begin
                    if (pos >= iyfp_pkg::FRAME_LAST)
                    begin
                        w.ok = (sum == b);
                        if (w.ok)
                            yaw = raw_to_deg(angle_lo, angle_hi);
                        w.yaw = yaw;
                        pending_words.push_back(w);
                        phase = iyfp_pkg::PH_HUNT;
                        pos = '0;
                        sum = '0;
                    end
                    else
                    begin
                        if (pos == iyfp_pkg::POS_ANGLE_LO)
                            angle_lo = b;
                        else if (pos == iyfp_pkg::POS_ANGLE_HI)
                            angle_hi = b;
                        sum = sum + b;
                        pos = pos + 4'd1;
                    end
                end
                default:
                begin
                    phase = iyfp_pkg::PH_HUNT;
                    if (b == iyfp_pkg::SYNC_BYTE)
                    begin
                        sum = iyfp_pkg::SYNC_BYTE;
                        phase = iyfp_pkg::PH_TYPE;
                        pos = iyfp_pkg::POS_TYPE;
                    end
                end
            endcase
        endfunction

        function void match_result(logic signed [8:0] yaw_got, logic ok_got);
            yaw_word_t w;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected result word yaw=%0d ok=%0b", $time, yaw_got, ok_got);
                errors++;
                return;
            end
            w = pending_words.pop_front();
            if (ok_got)
                good_frames++;
            else
                bad_frames++;
            if (yaw_got !== w.yaw)
            begin
                $display("%0t: yaw_degrees expected %0d actual %0d", $time, w.yaw, yaw_got);
                errors++;
            end
            if (ok_got !== w.ok)
            begin
                $display("%0t: checksum_ok expected %0b actual %0b", $time, w.ok, ok_got);
                errors++;
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [iyfp_pkg::ADDR_W-1:0]   paddr;
    logic [iyfp_pkg::DATA_W-1:0]   pwdata;
    logic [iyfp_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    logic [7:0]                    rx_byte;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [8:0]             yaw_degrees;
    logic                          checksum_ok;

    yaw_frame_tracker    sb;
    logic [7:0]          tx_bytes[$];
    bit                  calm;
    int                  bytes_sent;
    int                  settings_used;
    int                  idle_cycles;

    imu_yaw_frame_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .yaw_degrees (yaw_degrees),
        .checksum_ok (checksum_ok)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short gaps, a few long ones; none while calm
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_angle();
        logic [15:0] corners[8];
        corners = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
                    16'h0001, 16'h8001, 16'h00B6, 16'hFF4A};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 7)];
        return 16'($urandom_range(0, 65535));
    endfunction

    // Queue one frame; junk bytes go into the type wait, cut > 0 keeps only that many bytes.
    task automatic push_frame(input logic [15:0] raw, input bit corrupt,
                              input int junk, input int cut);
        logic [7:0] fr[$];
        logic [7:0] cs;
        int         i;
        fr.push_back(iyfp_pkg::SYNC_BYTE);
        for (i = 0; i < junk; i++)
            fr.push_back(8'($urandom_range(0, 255)));
        fr.push_back(sb.ptype);
        cs = iyfp_pkg::SYNC_BYTE + sb.ptype;
        for (i = 2; i < 10; i++)
        begin
            if (i == iyfp_pkg::POS_ANGLE_LO)
                fr.push_back(raw[7:0]);
            else if (i == iyfp_pkg::POS_ANGLE_HI)
                fr.push_back(raw[15:8]);
            else
                fr.push_back(8'($urandom_range(0, 255)));
            cs = cs + fr[fr.size() - 1];
        end
        if (corrupt)
            cs = cs ^ (8'd1 << $urandom_range(0, 7));
        fr.push_back(cs);
        for (i = 0; i < fr.size() && (cut == 0 || i < cut); i++)
            tx_bytes.push_back(fr[i]);
    endtask

    task automatic queue_random_chunk();
        int r;
        int i;
        r = $urandom_range(0, 99);
        if (r < 70)
            push_frame(pick_angle(), 1'b0, 0, 0);
        else if (r < 80)
            push_frame(pick_angle(), 1'b1, 0, 0);
        else if (r < 88)
        begin
            for (i = $urandom_range(1, 6); i > 0; i--)
                tx_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 94)
            push_frame(pick_angle(), 1'b0, 0, $urandom_range(1, 9));
        else
            push_frame(pick_angle(), 1'b0, $urandom_range(1, 4), 0);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        rx_byte <= b;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.take_byte(b);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic flush_bytes();
        while (tx_bytes.size() > 0)
            send_byte(tx_bytes.pop_front());
    endtask

    task automatic run_segment(input int n);
        int sent;
        sent = 0;
        while (sent < n)
        begin
            if (tx_bytes.size() == 0)
                queue_random_chunk();
            send_byte(tx_bytes.pop_front());
            sent++;
        end
        // leftover bytes are dropped, so the parser is often mid-frame here
        tx_bytes.delete();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [iyfp_pkg::ADDR_W-1:0] a,
                             input logic [iyfp_pkg::DATA_W-1:0] d);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (a == iyfp_pkg::ADDR_W'(4 * iyfp_pkg::REG_PACKET_TYPE))
            sb.ptype = d[7:0];
    endtask

    task automatic apb_check_type();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= iyfp_pkg::ADDR_W'(4 * iyfp_pkg::REG_PACKET_TYPE);
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== {24'h0, sb.ptype})
        begin
            $display("%0t: packet_type readback expected %0h actual %0h",
                     $time, {24'h0, sb.ptype}, prdata);
            sb.errors++;
        end
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // result word monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.match_result(yaw_degrees, checksum_ok);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no handshake for %0d cycles", $time, idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // output back-pressure
    initial
    begin
        int run;
        int gap;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            run = $urandom_range(1, 20);
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [7:0] type_plan[SEGMENTS];
        int         s;
        sb = new();
        calm = 1'b0;
        bytes_sent = 0;
        settings_used = 1;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        rx_byte <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: noise, sync then junk in the type wait, full-scale angles
        apb_check_type();
        tx_bytes = '{8'h00, 8'hFF, iyfp_pkg::SYNC_BYTE, iyfp_pkg::SYNC_BYTE, 8'h12};
        tx_bytes.pop_front();
        tx_bytes.pop_front();
        tx_bytes.pop_front();
        tx_bytes.pop_front();
        tx_bytes.pop_front();
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        push_frame(16'h8000, 1'b0, 2, 0);
        tx_bytes[3] = iyfp_pkg::SYNC_BYTE;
        tx_bytes[4] = 8'h12;
        push_frame(16'h7FFF, 1'b0, 0, 0);
        flush_bytes();

        type_plan = '{8'h00, 8'hFF, 8'h55, 8'($urandom_range(0, 255)),
                      iyfp_pkg::PACKET_TYPE_RESET,
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      iyfp_pkg::PACKET_TYPE_RESET};
        for (s = 0; s < SEGMENTS; s++)
        begin
            wait_idle();
            apb_write(iyfp_pkg::ADDR_W'(4 * iyfp_pkg::REG_PACKET_TYPE),
                      {16'($urandom_range(0, 65535)), 16'h0} |
                      iyfp_pkg::DATA_W'(type_plan[s]));
            sb.ptype = type_plan[s];
            if (s == 3)
                apb_write(iyfp_pkg::ADDR_W'(4), iyfp_pkg::DATA_W'($urandom_range(0, 255)));
            apb_check_type();
            settings_used++;
            calm = (s == 4);
            run_segment(SEGMENT_ITEMS);
        end
        calm = 1'b0;

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Sent %0d bytes under %0d packet-type settings", bytes_sent, settings_used);
        $display("Frames seen: %0d with good checksum, %0d with bad checksum",
                 sb.good_frames, sb.bad_frames);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: imu_yaw_frame_parser.f
rtl/iyfp_pkg.sv
rtl/iyfp_fifo.sv
rtl/iyfp_front.sv
rtl/iyfp_back.sv
rtl/imu_yaw_frame_parser.sv
test/tb.sv
